// ----- rtl/rha_pkg.sv -----
// Shared types and constants of the RGB histogram accumulator.
package rha_pkg;

  localparam int CHAN_W      = 8;
  localparam int NUM_CH      = 3;
  localparam int BIN_COUNT   = 256;
  localparam int BIN_W       = $clog2(BIN_COUNT);
  localparam int SIZE_W      = 12;
  localparam int OUT_COUNT_W = 24;
  localparam int SHARE_W     = 7;
  localparam int SHIFT_W     = $clog2(SHARE_W);
  localparam int TOTAL_W     = 2 * SIZE_W;
  localparam int SCALE_W     = 7;
  localparam int LIMIT_W     = TOTAL_W + SCALE_W;
  localparam int REG_IDX_W   = 4;

  localparam int PCT_SCALE   = 100;
  localparam int LIMIT_SCALE = 101;
  localparam int SHARE_CAP   = 100;

  // floor(s/3) = (s*683) >> 11 for every channel sum s up to 765
  localparam int SUM_W       = CHAN_W + 2;
  localparam int GRAY_PROD_W = 2 * SUM_W;
  localparam int GRAY_RECIP  = 683;
  localparam int GRAY_SHIFT  = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(1);

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [BIN_W-1:0]  bin;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]      gray_average;
    logic [OUT_COUNT_W-1:0] red_bin_count;
    logic [OUT_COUNT_W-1:0] green_bin_count;
    logic [OUT_COUNT_W-1:0] blue_bin_count;
    logic [SHARE_W-1:0]     red_share;
    logic [SHARE_W-1:0]     green_share;
    logic [SHARE_W-1:0]     blue_share;
    logic                   colour_seen;
  } result_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [SIZE_W-1:0]    reg_value;
  } cfg_t;

  // Control of the share divider lanes, driven by the top-level sequencer
  typedef struct packed {
    logic               load;
    logic               check;
    logic               iterate;
    logic [SHIFT_W-1:0] shift;
  } div_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WRITE,
    ST_RD_LOAD,
    ST_RD_DIV,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/rha_stream_if.sv -----
// Valid/ready channel carrying one payload item per handshake.
interface rha_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rha_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rha_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rha_share_div.sv -----
// One lane of the percentage divider: floor(count*100/total), capped at 100.
module rha_share_div import rha_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  div_ctrl_t             ctrl,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [TOTAL_W-1:0]    total,
  input  logic [LIMIT_W-1:0]    limit,
  output logic [SHARE_W-1:0]    share
);

  localparam int NUM_W = COUNT_BITS + SCALE_W;
  localparam int CMP_W = (NUM_W > LIMIT_W) ? NUM_W : LIMIT_W;

  logic [CMP_W-1:0]   num;
  logic [SHARE_W-1:0] quo;
  logic               capped;
  logic [CMP_W-1:0]   divisor;
  logic               fits;

  assign divisor = CMP_W'(total) << ctrl.shift;
  assign fits    = (num >= divisor);

  // Load the scaled count, flag quotients above 100, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num    <= CMP_W'(NUM_W'(count) * NUM_W'(PCT_SCALE));
      quo    <= '0;
      capped <= 1'b0;
    end else if (ctrl.check) begin
      capped <= (num >= CMP_W'(limit));
    end else if (ctrl.iterate) begin
      quo[ctrl.shift] <= fits;
      if (fits) begin
        num <= num - divisor;
      end
    end
  end

  assign share = capped ? SHARE_W'(SHARE_CAP) : quo;

endmodule

// ----- rtl/rgb_histogram_accumulator.sv -----
// Top level of the RGB histogram accumulator: sequencer, bin memories, divider lanes.
//
// Keeps three 256-bin histograms (red, green, blue) in three synchronous RAMs and
// answers one result item per input item. A pixel item (mode 0) reads the three
// bins named by its samples, adds one to each (a bin stops at 2^COUNT_BITS-1) and
// writes them back; its result carries floor((r+g+b)/3) and the sticky colour flag,
// which is set once any pixel has unequal channels. A read item (mode 1) returns
// the three counts of one bin and each count's share of image_width*image_height
// in percent (floored, capped at 100; a size register of 0 counts as 1). Items are
// handled one at a time: a pixel item occupies the block for a RAM read, write back
// and result hand-off; a read item for a RAM read, scaling multiply, one cap check,
// seven restoring-division steps run in three parallel lanes and result hand-off.
// The result register lets the next item enter while the previous result still
// waits downstream; a new result waits only if that register is still full. After
// reset the block sweeps all 256 bins to zero, one bin per cycle, and takes no item
// until the sweep ends; configuration writes are taken at all times, and an item
// is held off in the cycle of a write.
module rgb_histogram_accumulator import rha_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  rha_stream_if.sink   item,
  rha_stream_if.source result,
  rha_stream_if.sink   cfg
);

  state_t state, state_next;

  // Configuration and derived divisors
  logic [SIZE_W-1:0]  image_width;
  logic [SIZE_W-1:0]  image_height;
  logic [SIZE_W-1:0]  width_eff;
  logic [SIZE_W-1:0]  height_eff;
  logic [TOTAL_W-1:0] total;
  logic [LIMIT_W-1:0] limit;

  // Sequencer
  logic [BIN_W-1:0]   clr_addr;
  logic [SHIFT_W-1:0] step;
  logic               accept;
  logic               out_free;
  logic               load_result;
  logic               ram_we;
  logic               ram_clear;
  div_ctrl_t          div_ctrl;

  // Item held while it is worked on
  logic                  colour_flag;
  logic [CHAN_W-1:0]     gray;
  logic [SUM_W-1:0]      chan_sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [CHAN_W-1:0]     gray_next;

  // Per-channel datapath
  logic [CHAN_W-1:0]      sample    [NUM_CH];
  logic [BIN_W-1:0]       raddr     [NUM_CH];
  logic [BIN_W-1:0]       pix_addr  [NUM_CH];
  logic [BIN_W-1:0]       waddr     [NUM_CH];
  logic [COUNT_BITS-1:0]  rdata     [NUM_CH];
  logic [COUNT_BITS-1:0]  wdata     [NUM_CH];
  logic [COUNT_BITS-1:0]  bin_count [NUM_CH];
  logic [SHARE_W-1:0]     share     [NUM_CH];

  assign accept   = item.valid && item.ready;
  assign out_free = !result.valid || result.ready;

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data.reg_value;
        REG_IMAGE_HEIGHT: image_height <= cfg.data.reg_value;
        default: ;
      endcase
    end
  end

  assign width_eff  = (image_width  == '0) ? SIZE_W'(1) : image_width;
  assign height_eff = (image_height == '0) ? SIZE_W'(1) : image_height;

  // Pixel total and the cap threshold 101*total, one multiply per stage.
  // Both settle after a write, total first, before a read item needs them.
  always_ff @(posedge clk) begin
    total <= TOTAL_W'(width_eff) * TOTAL_W'(height_eff);
    limit <= LIMIT_W'(total) * LIMIT_W'(LIMIT_SCALE);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == BIN_W'(BIN_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.data.mode == MODE_READ) ? ST_RD_LOAD : ST_PIX_WRITE;
        end
      end
      ST_PIX_WRITE: state_next = ST_DONE;
      ST_RD_LOAD:   state_next = ST_RD_DIV;
      ST_RD_DIV: begin
        if (step == SHIFT_W'(SHARE_W)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    item.ready       = 1'b0;
    ram_we           = 1'b0;
    ram_clear        = 1'b0;
    load_result      = 1'b0;
    div_ctrl.load    = 1'b0;
    div_ctrl.check   = 1'b0;
    div_ctrl.iterate = 1'b0;
    div_ctrl.shift   = SHIFT_W'(SHARE_W) - step;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_clear = 1'b1;
      end
      ST_IDLE:      item.ready    = !cfg.valid;
      ST_PIX_WRITE: ram_we        = 1'b1;
      ST_RD_LOAD:   div_ctrl.load = 1'b1;
      ST_RD_DIV: begin
        div_ctrl.check   = (step == '0);
        div_ctrl.iterate = (step != '0);
      end
      ST_DONE:      load_result   = out_free;
      default: ;
    endcase
  end

  // Clear sweep address and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      step     <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BIN_W'(1);
      end
      if (state == ST_RD_DIV) begin
        step <= step + SHIFT_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side: channel average and colour flag, taken at acceptance
  // ---------------------------------------------------------------------------
  assign chan_sum  = SUM_W'(item.data.red) + SUM_W'(item.data.green)
                   + SUM_W'(item.data.blue);
  assign gray_prod = GRAY_PROD_W'(chan_sum) * GRAY_PROD_W'(GRAY_RECIP);
  assign gray_next = CHAN_W'(gray_prod >> GRAY_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_flag <= 1'b0;
    end else if (accept && item.data.mode == MODE_PIXEL) begin
      if (item.data.red != item.data.green || item.data.green != item.data.blue) begin
        colour_flag <= 1'b1;
      end
    end
  end

  // Hold the sample addresses for the write back; zero the average for reads
  always_ff @(posedge clk) begin
    if (accept) begin
      gray <= (item.data.mode == MODE_PIXEL) ? gray_next : '0;
      for (int c = 0; c < NUM_CH; c++) begin
        pix_addr[c] <= sample[c];
      end
    end
  end

  assign sample[0] = item.data.red;
  assign sample[1] = item.data.green;
  assign sample[2] = item.data.blue;

  // ---------------------------------------------------------------------------
  // Bin memories and divider lanes, one per channel
  // ---------------------------------------------------------------------------
  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    // Read at acceptance: the sample's bin for a pixel, the named bin for a read
    assign raddr[c] = (item.data.mode == MODE_READ) ? item.data.bin : sample[c];
    assign waddr[c] = ram_clear ? clr_addr : pix_addr[c];
    // Saturating increment of the bin just read; zero during the clear sweep
    assign wdata[c] = ram_clear ? '0 :
                      (&rdata[c]) ? rdata[c] : rdata[c] + COUNT_BITS'(1);

    rha_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_COUNT)
    ) u_bins (
      .clk   (clk),
      .we    (ram_we),
      .waddr (waddr[c]),
      .wdata (wdata[c]),
      .raddr (raddr[c]),
      .rdata (rdata[c])
    );

    always_ff @(posedge clk) begin
      if (state == ST_RD_LOAD) begin
        bin_count[c] <= rdata[c];
      end else if (state == ST_PIX_WRITE) begin
        bin_count[c] <= '0;
      end
    end

    rha_share_div #(
      .COUNT_BITS (COUNT_BITS)
    ) u_share (
      .clk   (clk),
      .ctrl  (div_ctrl),
      .count (rdata[c]),
      .total (total),
      .limit (limit),
      .share (share[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_result) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.data.gray_average    <= gray;
      result.data.red_bin_count   <= OUT_COUNT_W'(bin_count[0]);
      result.data.green_bin_count <= OUT_COUNT_W'(bin_count[1]);
      result.data.blue_bin_count  <= OUT_COUNT_W'(bin_count[2]);
      result.data.red_share       <= (state_next == ST_IDLE && bin_count[0] == '0) ?
                                     '0 : share[0];
      result.data.green_share     <= (bin_count[1] == '0) ? '0 : share[1];
      result.data.blue_share      <= (bin_count[2] == '0) ? '0 : share[2];
      result.data.colour_seen     <= colour_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_PIX_WRITE || state == ST_RD_LOAD))
    else $error("accepted item did not start a pixel update or a bin read");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the hand-off state");

  a_share_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.red_share <= SHARE_W'(SHARE_CAP) &&
                      result.data.green_share <= SHARE_W'(SHARE_CAP) &&
                      result.data.blue_share <= SHARE_W'(SHARE_CAP)))
    else $error("share above 100 percent");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_addr == BIN_W'(BIN_COUNT - 1)) |=> state == ST_IDLE)
    else $error("clear sweep did not end after the last bin");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the RGB histogram accumulator.
`timescale 1ns / 100ps

module tb_top;
  import rha_pkg::*;

  // Bin count width of the block under test.
  localparam int CNT_BITS     = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 24;   // watch time for stray results once every answer has arrived

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = REG_IDX_W'(15);

  localparam result_t UNTYPED = '0;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  rha_stream_if #(.payload_t(item_t))   item_ch ();
  rha_stream_if #(.payload_t(result_t)) result_ch ();
  rha_stream_if #(.payload_t(cfg_t))    cfg_ch ();

  rgb_histogram_accumulator #(.COUNT_BITS(CNT_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the block's histograms, color flag and size registers.
  logic [CNT_BITS-1:0] hist_red   [BIN_COUNT];
  logic [CNT_BITS-1:0] hist_green [BIN_COUNT];
  logic [CNT_BITS-1:0] hist_blue  [BIN_COUNT];
  logic                color_flag;
  logic [SIZE_W-1:0]   width_reg;
  logic [SIZE_W-1:0]   height_reg;

  // Answers owed by the block, oldest first.
  result_t answers_due [$];

  dir_row_t    dir_table [21];
  item_t       last_pixel;
  logic [CHAN_W-1:0] hot_value;

  int errors          = 0;
  int pixels_binned   = 0;
  int bins_read       = 0;
  int saturated_reads = 0;
  int capped_shares   = 0;
  int size_settings   = 1;
  int cycle_count     = 0;

  // Receiver stall pattern state.
  int epoch_left = 0;
  int stall_left = 0;
  int stall_pct  = 0;
  int stall_max  = 0;

  // Clock: 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Percentage of the image size, floored and capped; a zero register counts as 1.
  function automatic logic [SHARE_W-1:0] share_of_size(logic [CNT_BITS-1:0] count);
    longint w, h, pct;
    w = (width_reg == '0) ? 1 : longint'(width_reg);
    h = (height_reg == '0) ? 1 : longint'(height_reg);
    pct = (longint'(count) * PCT_SCALE) / (w * h);
    if (pct > SHARE_CAP) begin
      pct = SHARE_CAP;
      capped_shares++;
    end
    return SHARE_W'(pct);
  endfunction

  // Apply one accepted item to the shadow state and return the answer it earns.
  function automatic result_t bin_and_answer(item_t it);
    result_t res;
    int      sum;
    res = '0;
    if (it.mode == MODE_PIXEL) begin
      // Saturate: a full bin ignores further pixels.
      if (hist_red[it.red] != '1) hist_red[it.red] += 1'b1;
      if (hist_green[it.green] != '1) hist_green[it.green] += 1'b1;
      if (hist_blue[it.blue] != '1) hist_blue[it.blue] += 1'b1;
      if (it.red != it.green || it.green != it.blue) color_flag = 1'b1;
      sum = int'(it.red) + int'(it.green) + int'(it.blue);
      res.gray_average = CHAN_W'(sum / NUM_CH);
      pixels_binned++;
    end else begin
      res.red_bin_count   = OUT_COUNT_W'(hist_red[it.bin]);
      res.green_bin_count = OUT_COUNT_W'(hist_green[it.bin]);
      res.blue_bin_count  = OUT_COUNT_W'(hist_blue[it.bin]);
      res.red_share       = share_of_size(hist_red[it.bin]);
      res.green_share     = share_of_size(hist_green[it.bin]);
      res.blue_share      = share_of_size(hist_blue[it.bin]);
      if (hist_red[it.bin] == '1 || hist_green[it.bin] == '1 || hist_blue[it.bin] == '1)
        saturated_reads++;
      bins_read++;
    end
    res.colour_seen = color_flag;
    return res;
  endfunction

  function automatic result_t gray_only(logic [CHAN_W-1:0] gray, logic seen);
    result_t res;
    res = '0;
    res.gray_average = gray;
    res.colour_seen  = seen;
    return res;
  endfunction

  // Random item. In hot mode most samples hit one value so its bins pile up.
  function automatic item_t pick_item(bit hot);
    item_t it;
    it.red   = CHAN_W'($urandom);
    it.green = CHAN_W'($urandom);
    it.blue  = CHAN_W'($urandom);
    it.bin   = BIN_W'($urandom);
    it.mode  = ($urandom_range(99) < (hot ? 12 : 30)) ? MODE_READ : MODE_PIXEL;
    if (it.mode == MODE_PIXEL) begin
      if (hot) begin
        if ($urandom_range(19) != 0) it.red   = hot_value;
        if ($urandom_range(19) != 0) it.green = hot_value;
        if ($urandom_range(19) != 0) it.blue  = hot_value;
      end else if ($urandom_range(3) == 0) begin
        // Gray pixel: all channels equal.
        it.green = it.red;
        it.blue  = it.red;
      end
      last_pixel = it;
    end else begin
      // Aim half of the reads, three in four in hot mode, at bins that hold counts.
      case ($urandom_range(3))
        0: it.bin = last_pixel.red;
        1: it.bin = last_pixel.green;
        2: if (hot) it.bin = hot_value;
        default: ;
      endcase
    end
    return it;
  endfunction

  // Offer one item from the falling edge, hold it until taken, then predict.
  task automatic send_item(item_t it, bit typed = 1'b0, result_t want = UNTYPED);
    result_t predicted;
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    predicted = bin_and_answer(it);
    if (typed) predicted = want;
    answers_due.insert(answers_due.size(), predicted);
  endtask

  // Drop valid and hold it low for the given number of cycles.
  task automatic pause_sender(int cycles);
    @(negedge clk);
    item_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_answered();
    pause_sender(1);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfg_t'{idx, val};
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Change the image size only once the block has answered everything.
  task automatic set_image_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    wait_all_answered();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    size_settings++;
  endtask

  // Random items in bursts; some phases send with no gaps at all.
  task automatic run_random(int count, bit hot);
    int sent;
    int burst;
    int gap;
    int i;
    bit gappy;
    sent  = 0;
    gappy = ($urandom_range(3) != 0);
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (i = 0; i < burst && sent < count; i++) begin
        send_item(pick_item(hot));
        sent++;
      end
      gap = (!gappy || $urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) pause_sender(gap);
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Receiver: stall in epochs of random style -- none, short and frequent, or long and rare.
  always @(negedge clk) begin
    if (epoch_left == 0) begin
      epoch_left = $urandom_range(40, 160);
      case ($urandom_range(2))
        0: begin
          stall_pct = 0;
          stall_max = 0;
        end
        1: begin
          stall_pct = 30;
          stall_max = 3;
        end
        default: begin
          stall_pct = 10;
          stall_max = 15;
        end
      endcase
    end else begin
      epoch_left--;
    end
    if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      result_ch.ready <= 1'b0;
      stall_left = $urandom_range(stall_max);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Compare every accepted result with the oldest answer owed.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (answers_due.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = answers_due.pop_front();
        check_field("gray_average", want.gray_average, got.gray_average);
        check_field("red_bin_count", want.red_bin_count, got.red_bin_count);
        check_field("green_bin_count", want.green_bin_count, got.green_bin_count);
        check_field("blue_bin_count", want.blue_bin_count, got.blue_bin_count);
        check_field("red_share", want.red_share, got.red_share);
        check_field("green_share", want.green_share, got.green_share);
        check_field("blue_share", want.blue_share, got.blue_share);
        check_field("colour_seen", want.colour_seen, got.colour_seen);
      end
    end
  end

  // Watchdog: the run must finish well within the limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers still owed", cycle_count,
               answers_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // Known values on every input from time zero.
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    result_ch.ready = 1'b0;

    foreach (hist_red[i]) begin
      hist_red[i]   = '0;
      hist_green[i] = '0;
      hist_blue[i]  = '0;
    end
    color_flag = 1'b0;
    width_reg  = SIZE_RESET;
    height_reg = SIZE_RESET;
    last_pixel = '0;
    hot_value  = '0;

    // Directed rows at the reset size of 512 x 512. Typed answers: empty bins after
    // reset, extreme samples, and the sticky color flag turning on at the first
    // pixel with unequal channels. The rest go through the predictor.
    dir_table = '{
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, result_t'('0)},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b1, result_t'('0)},
      '{item_t'{MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, gray_only(8'd0, 1'b0)},
      '{item_t'{MODE_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0}, 1'b1, gray_only(8'd255, 1'b0)},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b1,
        result_t'{8'd0, 24'd1, 24'd1, 24'd1, 7'd0, 7'd0, 7'd0, 1'b0}},
      '{item_t'{MODE_PIXEL, 8'd128, 8'd128, 8'd128, 8'd0}, 1'b1, gray_only(8'd128, 1'b0)},
      '{item_t'{MODE_PIXEL, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b1, gray_only(8'd85, 1'b1)},
      '{item_t'{MODE_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b1, gray_only(8'd85, 1'b1)},
      '{item_t'{MODE_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b1, gray_only(8'd85, 1'b1)},
      '{item_t'{MODE_PIXEL, 8'd1, 8'd1, 8'd2, 8'd0}, 1'b1, gray_only(8'd1, 1'b1)},
      '{item_t'{MODE_PIXEL, 8'd254, 8'd255, 8'd255, 8'd0}, 1'b1, gray_only(8'd254, 1'b1)},
      // Bin field set on a pixel item: ignored.
      '{item_t'{MODE_PIXEL, 8'd170, 8'd85, 8'd0, 8'd255}, 1'b0, UNTYPED},
      '{item_t'{MODE_PIXEL, 8'd85, 8'd170, 8'd85, 8'd170}, 1'b0, UNTYPED},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, UNTYPED},
      // Sample fields set on a read item: ignored.
      '{item_t'{MODE_READ, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, UNTYPED},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd128}, 1'b0, UNTYPED},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b0, UNTYPED},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd254}, 1'b0, UNTYPED},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd85}, 1'b0, UNTYPED},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd170}, 1'b0, UNTYPED},
      '{item_t'{MODE_READ, 8'd0, 8'd0, 8'd0, 8'd2}, 1'b0, UNTYPED}
    };

    // Hold reset from time zero and release it on a falling edge. The block then clears
    // its bins; the first item simply waits for ready.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) send_item(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);

    // Random phases, each at its own image size; every size change drains the block.
    run_random(30, 1'b0);

    // One-pixel image: any nonzero count caps its share at 100.
    set_image_size(12'd1, 12'd1);
    run_random(40, 1'b0);

    // Zero width counts as 1; also poke unused indexes, which must change nothing.
    set_image_size(12'd0, 12'd3);
    write_reg(REG_SPARE_HI, 12'hFFF);
    write_reg(REG_SPARE_LO, 12'h5A5);
    run_random(30, 1'b0);

    // Largest image: every share floors to zero.
    set_image_size(12'hFFF, 12'hFFF);
    run_random(30, 1'b0);

    // Hammer one value so its bins pile up counts far above a small image size.
    hot_value = CHAN_W'($urandom);
    set_image_size(12'd37, 12'd3);
    run_random(330, 1'b1);

    set_image_size(SIZE_W'($urandom_range(1, 40)), SIZE_W'($urandom_range(1, 40)));
    run_random(40, 1'b0);

    // Zero height against the widest setting.
    set_image_size(12'hFFF, 12'd0);
    run_random(30, 1'b0);

    // Let every answer arrive, then watch a little longer for stray results.
    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (answers_due.size() != 0) begin
      $error("%0d answers never arrived", answers_due.size());
      errors++;
    end

    $display("Run covered %0d pixels binned and %0d bin reads over %0d image sizes",
             pixels_binned, bins_read, size_settings);
    $display("Saturated bins read %0d times, shares capped %0d times, %0d mismatches",
             saturated_reads, capped_shares, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
